### rtl/core/xibd_pkg.sv
// Shared types, constants and decode functions for the x86 instruction byte decoder.
package xibd_pkg;

  localparam logic [3:0] MAX_LENGTH = 4'd15;
  localparam logic [4:0] ZERO_REG   = 5'd31;
  localparam logic [4:0] RIP_REG    = 5'd30;

  // Legacy prefix bytes
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_ADSIZE = 8'h67;
  localparam logic [7:0] PFX_REPNE  = 8'hF2;
  localparam logic [7:0] PFX_REP    = 8'hF3;
  localparam logic [7:0] PFX_LOCK   = 8'hF0;
  localparam logic [7:0] PFX_ESCAPE = 8'h0F;
  localparam logic [7:0] PFX_ES     = 8'h26;
  localparam logic [7:0] PFX_CS     = 8'h2E;
  localparam logic [7:0] PFX_SS     = 8'h36;
  localparam logic [7:0] PFX_DS     = 8'h3E;
  localparam logic [7:0] PFX_FS     = 8'h64;
  localparam logic [7:0] PFX_GS     = 8'h65;

  localparam int unsigned PB_OPSIZE = 0;
  localparam int unsigned PB_ESCAPE = 5;

  // Mnemonic codes
  localparam logic [3:0] MN_UNKNOWN = 4'd0;
  localparam logic [3:0] MN_INC     = 4'd9;
  localparam logic [3:0] MN_TEST    = 4'd13;
  localparam logic [3:0] MN_XCHG    = 4'd14;
  localparam logic [3:0] MN_MOV     = 4'd15;

  // Operand forms
  localparam logic [2:0] FORM_NONE    = 3'd0;
  localparam logic [2:0] FORM_RM_REG  = 3'd1;
  localparam logic [2:0] FORM_REG_RM  = 3'd2;
  localparam logic [2:0] FORM_ACC_IMM = 3'd3;
  localparam logic [2:0] FORM_OP_REG  = 3'd4;
  localparam logic [2:0] FORM_OP_IMM  = 3'd5;

  // Operand sizes
  localparam logic [1:0] SZ_BYTE  = 2'd0;
  localparam logic [1:0] SZ_WORD  = 2'd1;
  localparam logic [1:0] SZ_DWORD = 2'd2;
  localparam logic [1:0] SZ_QWORD = 2'd3;

  // ModRM mod and rm field values, and the SIB no-index code
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_DISP32  = 3'd5;
  localparam logic [2:0] IDX_NONE   = 3'd4;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_OPCODE,
    PH_MODRM,
    PH_SIB,
    PH_DISP,
    PH_IMM
  } phase_e;

  typedef struct packed {
    logic [3:0]  byte_count;
    logic [11:0] prefix_bits;
    logic [7:0]  rex;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] disp;
    logic [63:0] imm;
  } insn_t;

  typedef struct packed {
    logic [3:0] mn;
    logic [2:0] form;
    logic       full;
  } class_t;

  typedef struct packed {
    logic [3:0]  length;
    logic [11:0] prefix_mask;
    logic [7:0]  rex_byte;
    logic [3:0]  mnemonic;
    logic [2:0]  operand_form;
    logic [1:0]  operand_size;
    logic [4:0]  reg_dest;
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    logic [1:0]  scale;
    logic [31:0] displacement;
    logic [63:0] immediate;
  } rec_t;

  function automatic logic [11:0] legacy_bit(input logic [7:0] b);
    logic [11:0] r;
    r = '0;
    unique case (b)
      PFX_OPSIZE: r = 12'h001;
      PFX_ADSIZE: r = 12'h002;
      PFX_REPNE:  r = 12'h004;
      PFX_REP:    r = 12'h008;
      PFX_LOCK:   r = 12'h010;
      PFX_ESCAPE: r = 12'h020;
      PFX_ES:     r = 12'h040;
      PFX_CS:     r = 12'h080;
      PFX_SS:     r = 12'h100;
      PFX_DS:     r = 12'h200;
      PFX_FS:     r = 12'h400;
      PFX_GS:     r = 12'h800;
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Non-byte operand size: REX.W wins over the operand-size prefix
  function automatic logic [1:0] full_size(input logic [7:0] rex, input logic [11:0] pfx);
    logic [1:0] r;
    if (rex[3])              r = SZ_QWORD;
    else if (pfx[PB_OPSIZE]) r = SZ_WORD;
    else                     r = SZ_DWORD;
    return r;
  endfunction

  function automatic class_t classify(input logic [7:0] op, input logic [11:0] pfx,
                                      input logic lm);
    class_t c;
    c = '{mn: MN_UNKNOWN, form: FORM_NONE, full: 1'b0};
    if (!pfx[PB_ESCAPE]) begin
      if (op < 8'h40 && op[2:0] < 3'd6) begin
        c.mn   = {1'b0, op[5:3]} + 4'd1;
        c.form = (op[2:1] == 2'd0) ? FORM_RM_REG :
                 (op[2:1] == 2'd1) ? FORM_REG_RM : FORM_ACC_IMM;
        c.full = op[0];
      end else if (op >= 8'h40 && op < 8'h60) begin
        if (!(op < 8'h50 && lm)) begin
          c.mn   = MN_INC + {2'b00, op[4:3]};
          c.form = FORM_OP_REG;
          c.full = 1'b1;
        end
      end else if (op >= 8'h84 && op <= 8'h8B) begin
        c.mn   = (op < 8'h86) ? MN_TEST : (op < 8'h88) ? MN_XCHG : MN_MOV;
        c.form = (op >= 8'h8A) ? FORM_REG_RM : FORM_RM_REG;
        c.full = op[0];
      end else if (op >= 8'hB0) begin
        if (op <= 8'hBF) begin
          c.mn   = MN_MOV;
          c.form = FORM_OP_IMM;
          c.full = op[3];
        end
      end
    end
    return c;
  endfunction

  // Immediate length in bytes; the accumulator quad form takes four
  function automatic logic [3:0] imm_len(input class_t c, input logic [1:0] sz);
    logic [3:0] r;
    r = 4'd0;
    if (c.form == FORM_ACC_IMM || c.form == FORM_OP_IMM) begin
      if (!c.full)          r = 4'd1;
      else if (sz == SZ_WORD) r = 4'd2;
      else if (sz == SZ_QWORD && c.form == FORM_OP_IMM) r = 4'd8;
      else                  r = 4'd4;
    end
    return r;
  endfunction

endpackage

### rtl/core/xibd_record.sv
// Builds the decoded result record from the gathered instruction state.
module xibd_record (
  input  xibd_pkg::insn_t st_i,
  input  logic            long_mode_i,
  input  logic            valid_i,
  output xibd_pkg::rec_t  rec_o
);
  import xibd_pkg::*;

  class_t     cls;
  logic [1:0] mod_f;
  logic [2:0] rm_f;
  logic [4:0] sib_idx;

  assign cls     = classify(st_i.opcode, st_i.prefix_bits, long_mode_i);
  assign mod_f   = st_i.modrm[7:6];
  assign rm_f    = st_i.modrm[2:0];
  assign sib_idx = {st_i.rex[1], 1'b0, st_i.sib[5:3]};

  always_comb begin
    rec_o              = '0;
    rec_o.length       = st_i.byte_count;
    rec_o.prefix_mask  = st_i.prefix_bits;
    rec_o.rex_byte     = st_i.rex;
    rec_o.base_reg     = ZERO_REG;
    rec_o.index_reg    = ZERO_REG;
    if (valid_i) begin
      rec_o.mnemonic     = cls.mn;
      rec_o.operand_form = cls.form;
      if (cls.form != FORM_NONE && cls.full)
        rec_o.operand_size = full_size(st_i.rex, st_i.prefix_bits);
      rec_o.immediate    = st_i.imm;
      case (cls.form)
        FORM_ACC_IMM: begin
          rec_o.index_reg = '0;
        end
        FORM_OP_REG, FORM_OP_IMM: begin
          rec_o.reg_dest  = {st_i.rex[0], 1'b0, st_i.opcode[2:0]};
          rec_o.index_reg = {st_i.rex[0], 1'b0, st_i.opcode[2:0]};
        end
        FORM_RM_REG, FORM_REG_RM: begin
          rec_o.reg_dest = {st_i.rex[2], 1'b0, st_i.modrm[5:3]};
          if (mod_f == MOD_REG) begin
            rec_o.index_reg = {st_i.rex[0], 1'b0, rm_f};
          end else if (rm_f == RM_SIB) begin
            // SIB addressing: no base with mod 0 and base 101, no index for 100
            if (mod_f == MOD_NODISP && st_i.sib[2:0] == RM_DISP32)
              rec_o.base_reg = ZERO_REG;
            else
              rec_o.base_reg = {st_i.rex[0], 1'b0, st_i.sib[2:0]};
            rec_o.index_reg = (sib_idx == {2'b00, IDX_NONE}) ? ZERO_REG : sib_idx;
            rec_o.scale     = st_i.sib[7:6];
          end else if (mod_f == MOD_NODISP && rm_f == RM_DISP32) begin
            rec_o.base_reg = long_mode_i ? RIP_REG : ZERO_REG;
          end else begin
            rec_o.base_reg = {st_i.rex[0], 1'b0, rm_f};
          end
          if (mod_f == MOD_DISP8)
            rec_o.displacement = {{24{st_i.disp[7]}}, st_i.disp[7:0]};
          else if (mod_f != MOD_REG)
            rec_o.displacement = st_i.disp;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/x86_instruction_byte_decoder_top.sv
// Top level of the x86 instruction byte decoder.
//
// Instruction bytes enter one beat at a time on the in channel (valid/ready)
// in address order. Each beat advances the decode state: prefixes, REX,
// opcode, ModRM, SIB, displacement and immediate. On the byte that ends an
// instruction, or once fifteen bytes pass without an end, one record beat is
// loaded into the output register and offered on the out channel.
// The record is registered and appears in the cycle after the final byte is taken.
// Throughput: one byte per cycle while the out channel is not stalled; the step
// logic sits between the state registers and the output register in a single pass.
// When the receiver stalls, the held record stays on the outputs and
// in_ready_o drops, so no byte is taken until that record is taken; a byte
// may be taken in the same cycle as the held record.
// Reset clears the decode state and the output valid; long_mode resets to 1.
// long_mode is written through cfg_we_i/cfg_wdata_i with no wait.
module x86_instruction_byte_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         instruction_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         length_o,
  output logic [11:0]        prefix_mask_o,
  output logic [7:0]         rex_byte_o,
  output logic [3:0]         mnemonic_o,
  output logic [2:0]         operand_form_o,
  output logic [1:0]         operand_size_o,
  output logic [4:0]         reg_dest_o,
  output logic [4:0]         base_reg_o,
  output logic [4:0]         index_reg_o,
  output logic [1:0]         scale_o,
  output logic signed [31:0] displacement_o,
  output logic [63:0]        immediate_o
);
  import xibd_pkg::*;

  logic       long_mode_q;
  phase_e     phase_q, phase_d;
  insn_t      st_q, st_d;
  logic [3:0] left_q, left_d;
  rec_t       rec_d, rec_q;
  logic       out_valid_q;
  logic       accept, done, too_long, emit, space;
  logic [7:0] b;
  class_t     cls_new, cls_cur;
  logic [3:0] n_imm_new, n_imm_cur, n_disp, pos4;
  logic [11:0] pbit;

  assign b         = instruction_byte_i;
  assign space     = !out_valid_q || out_ready_i;
  assign in_ready_o = space;
  assign accept    = in_valid_i && in_ready_o;

  assign pbit      = legacy_bit(b);
  assign cls_new   = classify(b, st_q.prefix_bits, long_mode_q);
  assign n_imm_new = imm_len(cls_new, full_size(st_q.rex, st_q.prefix_bits));
  assign cls_cur   = classify(st_q.opcode, st_q.prefix_bits, long_mode_q);
  assign n_imm_cur = imm_len(cls_cur, full_size(st_q.rex, st_q.prefix_bits));
  assign n_disp    = (st_q.modrm[7:6] == MOD_DISP8) ? 4'd1 : 4'd4;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      long_mode_q <= cfg_wdata_i;
    end
  end

  // One decode step for the incoming byte
  always_comb begin
    phase_d            = phase_q;
    st_d               = st_q;
    left_d             = left_q;
    done               = 1'b0;
    pos4               = 4'd0;
    st_d.byte_count    = st_q.byte_count + 4'd1;
    unique case (phase_q)
      PH_PREFIX, PH_OPCODE: begin
        if (phase_q == PH_PREFIX && pbit != '0) begin
          st_d.prefix_bits = st_q.prefix_bits | pbit;
        end else if (phase_q == PH_PREFIX && long_mode_q && b[7:4] == 4'h4) begin
          st_d.rex = b;
          phase_d  = PH_OPCODE;
        end else begin
          st_d.opcode = b;
          if (cls_new.form == FORM_RM_REG || cls_new.form == FORM_REG_RM) begin
            phase_d = PH_MODRM;
          end else if (n_imm_new != 4'd0) begin
            phase_d = PH_IMM;
            left_d  = n_imm_new;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_MODRM: begin
        st_d.modrm = b;
        if (b[7:6] == MOD_REG) begin
          done = 1'b1;
        end else if (b[2:0] == RM_SIB) begin
          phase_d = PH_SIB;
        end else if (b[7:6] == MOD_NODISP && b[2:0] != RM_DISP32) begin
          done = 1'b1;
        end else begin
          phase_d = PH_DISP;
          left_d  = (b[7:6] == MOD_DISP8) ? 4'd1 : 4'd4;
        end
      end
      PH_SIB: begin
        st_d.sib = b;
        if (st_q.modrm[7:6] == MOD_NODISP && b[2:0] != RM_DISP32) begin
          done = 1'b1;
        end else begin
          phase_d = PH_DISP;
          left_d  = (st_q.modrm[7:6] == MOD_DISP8) ? 4'd1 : 4'd4;
        end
      end
      PH_DISP: begin
        pos4 = n_disp - left_q;
        case (pos4[1:0])
          2'd0:    st_d.disp[7:0]   = st_q.disp[7:0]   | b;
          2'd1:    st_d.disp[15:8]  = st_q.disp[15:8]  | b;
          2'd2:    st_d.disp[23:16] = st_q.disp[23:16] | b;
          default: st_d.disp[31:24] = st_q.disp[31:24] | b;
        endcase
        if (left_q != 4'd0) left_d = left_q - 4'd1;
        done = (left_d == 4'd0);
      end
      PH_IMM: begin
        pos4 = n_imm_cur - left_q;
        case (pos4[2:0])
          3'd0:    st_d.imm[7:0]   = st_q.imm[7:0]   | b;
          3'd1:    st_d.imm[15:8]  = st_q.imm[15:8]  | b;
          3'd2:    st_d.imm[23:16] = st_q.imm[23:16] | b;
          3'd3:    st_d.imm[31:24] = st_q.imm[31:24] | b;
          3'd4:    st_d.imm[39:32] = st_q.imm[39:32] | b;
          3'd5:    st_d.imm[47:40] = st_q.imm[47:40] | b;
          3'd6:    st_d.imm[55:48] = st_q.imm[55:48] | b;
          default: st_d.imm[63:56] = st_q.imm[63:56] | b;
        endcase
        if (left_q != 4'd0) left_d = left_q - 4'd1;
        done = (left_d == 4'd0);
      end
      default: ;
    endcase
    too_long = !done && (st_d.byte_count >= MAX_LENGTH);
  end

  assign emit = accept && (done || too_long);

  xibd_record u_record (
    .st_i        (st_d),
    .long_mode_i (long_mode_q),
    .valid_i     (done),
    .rec_o       (rec_d)
  );

  // Decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      st_q    <= '0;
      left_q  <= '0;
    end else if (emit) begin
      phase_q <= PH_PREFIX;
      st_q    <= '0;
      left_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      st_q    <= st_d;
      left_q  <= left_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign length_o       = rec_q.length;
  assign prefix_mask_o  = rec_q.prefix_mask;
  assign rex_byte_o     = rec_q.rex_byte;
  assign mnemonic_o     = rec_q.mnemonic;
  assign operand_form_o = rec_q.operand_form;
  assign operand_size_o = rec_q.operand_size;
  assign reg_dest_o     = rec_q.reg_dest;
  assign base_reg_o     = rec_q.base_reg;
  assign index_reg_o    = rec_q.index_reg;
  assign scale_o        = rec_q.scale;
  assign displacement_o = $signed(rec_q.displacement);
  assign immediate_o    = rec_q.immediate;

endmodule
